/* sv/rmlp_pkg.sv */
// ============================================================================
// rmlp_pkg: shared types and constants for the recurrent MLP engine
// Holds the term tag that rides the MAC pipeline, datapath widths and the
// sigmoid breakpoint table.
// ============================================================================
package rmlp_pkg;

   localparam int WORD_W = 16;   // Q4.12 weights, inputs, bias
   localparam int ACT_W  = 13;   // Q0.12 activations, 0..4096
   localparam int ACC_W  = 32;   // Q8.24 accumulator

   // One multiply-accumulate term moving down the pipeline.
   typedef struct packed {
      logic valid;
      logic first;      // start a fresh sum
      logic last;       // sum complete after this term
      logic out_phase;  // output layer (else hidden layer)
   } term_tag_type;

   // Sigmoid at steps of 0.5 on [0,8], Q0.12.
   function automatic logic [11:0] sig_point(input logic [4:0] idx);
      logic [11:0] v;
      case (idx)
         5'd0:    v = 12'd2048;
         5'd1:    v = 12'd2550;
         5'd2:    v = 12'd2994;
         5'd3:    v = 12'd3349;
         5'd4:    v = 12'd3608;
         5'd5:    v = 12'd3785;
         5'd6:    v = 12'd3902;
         5'd7:    v = 12'd3976;
         5'd8:    v = 12'd4022;
         5'd9:    v = 12'd4051;
         5'd10:   v = 12'd4069;
         5'd11:   v = 12'd4079;
         5'd12:   v = 12'd4086;
         5'd13:   v = 12'd4090;
         5'd14:   v = 12'd4092;
         5'd15:   v = 12'd4094;
         default: v = 12'd4095;
      endcase
      return v;
   endfunction

endpackage

/* sv/rmlp_frame_cell.sv */
// ============================================================================
// rmlp_frame_cell: one remembered hidden frame
// A ring of activations that rotates one entry per shift; the entry leaving
// the head re-enters at the tail, or is replaced by a decayed value handed
// over from the neighbor frame.
// ============================================================================
module rmlp_frame_cell #(
   parameter int DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic                      take,
   input  logic [rmlp_pkg::ACT_W-1:0] src_value,
   input  logic [rmlp_pkg::ACT_W-1:0] decay,
   output logic [rmlp_pkg::ACT_W-1:0] head
);
   import rmlp_pkg::*;

   logic [ACT_W-1:0]   ring_ff [DEPTH];
   logic [2*ACT_W-1:0] scaled;
   logic [ACT_W-1:0]   tail_in;

   // entry = (value * decay + 2048) >> 12
   assign scaled  = src_value * decay + (2*ACT_W)'(2048);
   assign tail_in = take ? scaled[ACT_W+11:12] : ring_ff[0];
   assign head    = ring_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) ring_ff[k] <= '0;
      end else if (shift) begin
         for (int k = 0; k < DEPTH - 1; k++) ring_ff[k] <= ring_ff[k+1];
         ring_ff[DEPTH-1] <= tail_in;
      end
   end

endmodule

/* sv/rmlp_sigmoid.sv */
// ============================================================================
// rmlp_sigmoid: two-stage table sigmoid
// Stage one folds the sum to a magnitude and splits segment and fraction;
// stage two interpolates between table points and mirrors negative sums.
// ============================================================================
module rmlp_sigmoid (
   input  logic                        clock,
   input  logic                        reset,
   input  rmlp_pkg::term_tag_type      in_tag,
   input  logic [rmlp_pkg::ACC_W-1:0]  in_acc,
   output rmlp_pkg::term_tag_type      out_tag,
   output logic [rmlp_pkg::ACT_W-1:0]  out_value,
   output logic                        busy
);
   import rmlp_pkg::*;

   term_tag_type     a_tag_ff, b_tag_ff;
   logic             neg_ff, sat_ff;
   logic [3:0]       seg_ff;
   logic [10:0]      frac_ff;
   logic [ACT_W-1:0] value_ff;

   logic [ACC_W-1:0] mag;
   logic [11:0]      lo, hi, diff;
   logic [22:0]      slope;
   logic [11:0]      interp;
   logic [ACT_W-1:0] v, value_in;

   assign mag = in_acc[ACC_W-1] ? (~in_acc + 1'b1) : in_acc;

   always_comb begin
      lo       = sig_point({1'b0, seg_ff});
      hi       = sig_point({1'b0, seg_ff} + 5'd1);
      diff     = hi - lo;
      slope    = diff * frac_ff + 23'd1024;
      interp   = 12'(slope[22:11]);
      v        = sat_ff ? ACT_W'(4095) : ACT_W'(lo) + ACT_W'(interp);
      value_in = neg_ff ? ACT_W'(4096) - v : v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
      end else begin
         a_tag_ff <= in_tag;
         b_tag_ff <= a_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= in_acc[ACC_W-1];
      sat_ff   <= |mag[31:27];
      seg_ff   <= mag[26:23];
      frac_ff  <= mag[22:12];
      value_ff <= value_in;
   end

   assign out_tag   = b_tag_ff;
   assign out_value = value_ff;
   assign busy      = a_tag_ff.valid || b_tag_ff.valid;

endmodule

/* sv/recurrent_mlp_inference.sv */
// ============================================================================
// recurrent_mlp_inference: Elman recurrent two-layer sigmoid network
// Weight beats fill the weight memory, input beats fill the input vector,
// and the beat marked last runs one pass: hidden layer, frame shift, output
// layer, one result beat per output neuron.
// ============================================================================
// Weight beats and non-last input beats are taken back to back while idle.
// A pass's length is set by the single MAC and the frame rings, which
// rotate a full MAX_HIDDEN entries per remembered frame.
// Throughput: one pass at a time; req_stall is high for the whole pass.
// Reset: synchronous; clears control and all frames to zero and loads
// the configuration defaults.
module recurrent_mlp_inference #(
   parameter int MAX_INPUTS       = 32,
   parameter int MAX_HIDDEN       = 32,
   parameter int MAX_OUTPUTS      = 16,
   parameter int MAX_MEMORY_ORDER = 4,
   parameter int WEIGHT_DEPTH     = 8192
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [12:0] req_weight_address,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_input_value,
   input  logic        req_input_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_output_value,
   output logic [3:0]  rsp_output_index,
   output logic        rsp_output_last,
   // configuration
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rmlp_pkg::*;

   localparam int IA    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int ICW   = $clog2(MAX_INPUTS + 1);
   localparam int PW    = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int HCW   = $clog2(MAX_HIDDEN + 1);
   localparam int OCW   = $clog2(MAX_OUTPUTS + 1);
   localparam int NW    = (HCW > OCW) ? HCW : OCW;
   localparam int WAW   = $clog2(WEIGHT_DEPTH);
   localparam int NCELL = (MAX_MEMORY_ORDER > 0) ? MAX_MEMORY_ORDER : 1;

   localparam logic OP_WEIGHT = 1'b0;

   typedef enum logic [2:0] {
      CFG_NUM_INPUTS   = 3'd0,
      CFG_NUM_HIDDEN   = 3'd1,
      CFG_NUM_OUTPUTS  = 3'd2,
      CFG_MEMORY_ORDER = 3'd3,
      CFG_BIAS_VALUE   = 3'd4,
      CFG_MEMORY_DECAY = 3'd5
   } cfg_index_type;

   typedef enum logic [1:0] {
      SRC_HOLD   = 2'd0,
      SRC_INPUT  = 2'd1,
      SRC_HIDDEN = 2'd2
   } opnd_src_type;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_HID_START = 12'b0000_0000_0010,
      ST_HID_IN    = 12'b0000_0000_0100,
      ST_HID_MEM   = 12'b0000_0000_1000,
      ST_HID_BIAS  = 12'b0000_0001_0000,
      ST_HID_DRAIN = 12'b0000_0010_0000,
      ST_UPD_PRE   = 12'b0000_0100_0000,
      ST_UPD       = 12'b0000_1000_0000,
      ST_OUT_START = 12'b0001_0000_0000,
      ST_OUT_HID   = 12'b0010_0000_0000,
      ST_OUT_BIAS  = 12'b0100_0000_0000,
      ST_OUT_DRAIN = 12'b1000_0000_0000
   } state_type;

   // ---------------------------------------------------------------- config
   logic [5:0]         num_inputs_ff, num_hidden_ff;
   logic [4:0]         num_outputs_ff;
   logic [2:0]         memory_order_ff;
   logic signed [15:0] bias_value_ff;
   logic [12:0]        memory_decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_inputs_ff   <= 6'd1;
         num_hidden_ff   <= 6'd1;
         num_outputs_ff  <= 5'd1;
         memory_order_ff <= 3'd0;
         bias_value_ff   <= 16'sd4096;
         memory_decay_ff <= 13'd4096;
      end else if (csr_write) begin
         case (csr_index)
            CFG_NUM_INPUTS:   num_inputs_ff   <= csr_data[5:0];
            CFG_NUM_HIDDEN:   num_hidden_ff   <= csr_data[5:0];
            CFG_NUM_OUTPUTS:  num_outputs_ff  <= csr_data[4:0];
            CFG_MEMORY_ORDER: memory_order_ff <= csr_data[2:0];
            CFG_BIAS_VALUE:   bias_value_ff   <= csr_data;
            CFG_MEMORY_DECAY: memory_decay_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Clamp counts to what the storage holds; decay above one acts as one.
   logic [5:0]  ni, nh;
   logic [4:0]  no;
   logic [2:0]  mo;
   logic [12:0] d_eff;

   always_comb begin
      ni    = (32'(num_inputs_ff) > MAX_INPUTS) ? 6'(MAX_INPUTS) : num_inputs_ff;
      nh    = (32'(num_hidden_ff) > MAX_HIDDEN) ? 6'(MAX_HIDDEN) : num_hidden_ff;
      no    = (32'(num_outputs_ff) > MAX_OUTPUTS) ? 5'(MAX_OUTPUTS) : num_outputs_ff;
      mo    = (32'(memory_order_ff) > MAX_MEMORY_ORDER) ?
              3'(MAX_MEMORY_ORDER) : memory_order_ff;
      d_eff = (memory_decay_ff > 13'd4096) ? 13'd4096 : memory_decay_ff;
   end

   // ---------------------------------------------------------------- state
   state_type       state_ff, state_in;
   logic [IA-1:0]   in_idx_ff, in_idx_in;
   logic [PW-1:0]   p_ff, p_in;
   logic [2:0]      f_ff, f_in;
   logic [NW-1:0]   nrn_ff, nrn_in;
   logic [WAW-1:0]  wa_ff, wa_in;
   logic            started_ff, started_in;
   logic [ICW-1:0]  in_count_ff;
   logic [PW-1:0]   hw_cnt_ff;
   logic [OCW-1:0]  out_cnt_ff;

   logic req_accept, weight_we, input_beat, pass_start;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign weight_we  = req_accept && (req_operation == OP_WEIGHT);
   assign input_beat = req_accept && (req_operation != OP_WEIGHT);
   assign pass_start = input_beat && req_input_last;

   // ---------------------------------------------------------------- stores
   logic signed [WORD_W-1:0] weight_mem [WEIGHT_DEPTH];
   logic signed [WORD_W-1:0] input_mem  [MAX_INPUTS];
   logic [ACT_W-1:0]         hidden_mem [MAX_HIDDEN];

   logic signed [WORD_W-1:0] w_rdata_ff, in_rdata_ff;
   logic [ACT_W-1:0]         hid_rdata_ff;
   logic [PW-1:0]            hid_raddr;

   term_tag_type     sig_tag;
   logic [ACT_W-1:0] sig_value;
   logic             sig_busy;
   logic             hid_result, out_result;

   assign hid_result = sig_tag.valid && !sig_tag.out_phase;
   assign out_result = sig_tag.valid && sig_tag.out_phase;

   always_ff @(posedge clock) begin
      if (weight_we) weight_mem[WAW'(req_weight_address)] <= req_weight_value;
      w_rdata_ff <= weight_mem[wa_ff];
   end

   always_ff @(posedge clock) begin
      if (input_beat && (32'(in_count_ff) < MAX_INPUTS))
         input_mem[in_count_ff[IA-1:0]] <= req_input_value;
      in_rdata_ff <= input_mem[in_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (hid_result) hidden_mem[hw_cnt_ff] <= sig_value;
      hid_rdata_ff <= hidden_mem[hid_raddr];
   end

   // ---------------------------------------------------------------- frames
   // Cell c holds frame c (oldest first). All rings rotate together, so the
   // heads always show the same entry index. During the update sweep each
   // kept frame takes the decayed entry of its younger neighbor and the
   // newest frame takes the decayed hidden activation.
   logic [ACT_W-1:0] heads [NCELL];
   logic             ring_shift, ring_upd;
   logic             pos_live;

   assign pos_live = (32'(p_ff) < 32'(nh));

   for (genvar c = 0; c < NCELL; c++) begin : g_frame
      logic [ACT_W-1:0] src;
      logic             take;
      if (c == NCELL - 1) begin : g_tail
         assign src = hid_rdata_ff;
      end else begin : g_mid
         assign src = (c + 1 == 32'(mo)) ? hid_rdata_ff : heads[c+1];
      end
      assign take = ring_upd && pos_live && (c < 32'(mo));
      rmlp_frame_cell #(.DEPTH(MAX_HIDDEN)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (ring_shift),
         .take      (take),
         .src_value (src),
         .decay     (d_eff),
         .head      (heads[c])
      );
   end

   logic [ACT_W-1:0] head_sel;
   always_comb begin
      head_sel = '0;
      for (int c = 0; c < NCELL; c++)
         if (32'(f_ff) == c) head_sel = heads[c];
   end

   // ---------------------------------------------------------------- sequencer
   term_tag_type             iss;
   opnd_src_type             iss_src;
   logic signed [WORD_W-1:0] iss_opnd;
   logic                     issue;
   logic                     pipe_empty;
   term_tag_type             t1_ff, t2_ff, t3_ff;

   assign pipe_empty = !t1_ff.valid && !t2_ff.valid && !t3_ff.valid && !sig_busy;

   always_comb begin
      state_in   = state_ff;
      in_idx_in  = in_idx_ff;
      p_in       = p_ff;
      f_in       = f_ff;
      nrn_in     = nrn_ff;
      wa_in      = wa_ff;
      started_in = started_ff;
      iss        = '0;
      iss_src    = SRC_HOLD;
      iss_opnd   = '0;
      issue      = 1'b0;
      hid_raddr  = p_ff;
      ring_shift = 1'b0;
      ring_upd   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (pass_start) begin
               nrn_in   = '0;
               wa_in    = '0;
               state_in = ST_HID_START;
            end
         end
         ST_HID_START: begin
            started_in = 1'b0;
            in_idx_in  = '0;
            p_in       = '0;
            f_in       = '0;
            if (32'(nrn_ff) == 32'(nh)) state_in = ST_HID_DRAIN;
            else if (ni != '0)          state_in = ST_HID_IN;
            else if (mo != '0)          state_in = ST_HID_MEM;
            else                        state_in = ST_HID_BIAS;
         end
         ST_HID_IN: begin
            issue     = 1'b1;
            iss_src   = SRC_INPUT;
            in_idx_in = in_idx_ff + 1'b1;
            if (32'(in_idx_ff) + 1 == 32'(ni))
               state_in = (mo != '0) ? ST_HID_MEM : ST_HID_BIAS;
         end
         ST_HID_MEM: begin
            // rotate every position, spend a weight only on live ones
            ring_shift = 1'b1;
            iss_opnd   = WORD_W'(head_sel);
            issue      = pos_live;
            if (32'(p_ff) == MAX_HIDDEN - 1) begin
               p_in = '0;
               f_in = f_ff + 1'b1;
               if (f_ff + 1'b1 == mo) state_in = ST_HID_BIAS;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         ST_HID_BIAS: begin
            issue    = 1'b1;
            iss.last = 1'b1;
            iss_opnd = bias_value_ff;
            nrn_in   = nrn_ff + 1'b1;
            state_in = ST_HID_START;
         end
         ST_HID_DRAIN: begin
            if (pipe_empty) begin
               p_in     = '0;
               nrn_in   = '0;
               state_in = (mo != '0) ? ST_UPD_PRE : ST_OUT_START;
            end
         end
         ST_UPD_PRE: begin
            hid_raddr = '0;
            state_in  = ST_UPD;
         end
         ST_UPD: begin
            ring_shift = 1'b1;
            ring_upd   = 1'b1;
            hid_raddr  = p_ff + 1'b1;
            if (32'(p_ff) == MAX_HIDDEN - 1) begin
               p_in     = '0;
               state_in = ST_OUT_START;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         ST_OUT_START: begin
            started_in = 1'b0;
            p_in       = '0;
            if (32'(nrn_ff) == 32'(no))
               state_in = ST_OUT_DRAIN;
            else if (pipe_empty && !rsp_valid)
               state_in = (nh != '0) ? ST_OUT_HID : ST_OUT_BIAS;
         end
         ST_OUT_HID: begin
            issue         = 1'b1;
            iss.out_phase = 1'b1;
            iss_src       = SRC_HIDDEN;
            p_in          = p_ff + 1'b1;
            if (32'(p_ff) + 1 == 32'(nh)) state_in = ST_OUT_BIAS;
         end
         ST_OUT_BIAS: begin
            issue         = 1'b1;
            iss.out_phase = 1'b1;
            iss.last      = 1'b1;
            iss_opnd      = bias_value_ff;
            nrn_in        = nrn_ff + 1'b1;
            state_in      = ST_OUT_START;
         end
         ST_OUT_DRAIN: begin
            if (pipe_empty) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // weights of a pass are consumed in address order
      if (issue) begin
         iss.valid  = 1'b1;
         iss.first  = !started_ff;
         started_in = 1'b1;
         wa_in      = wa_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_idx_ff   <= '0;
         p_ff        <= '0;
         f_ff        <= '0;
         nrn_ff      <= '0;
         wa_ff       <= '0;
         started_ff  <= 1'b0;
         in_count_ff <= '0;
         hw_cnt_ff   <= '0;
         out_cnt_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         in_idx_ff  <= in_idx_in;
         p_ff       <= p_in;
         f_ff       <= f_in;
         nrn_ff     <= nrn_in;
         wa_ff      <= wa_in;
         started_ff <= started_in;
         // drop elements past the buffer, rewind on the last one
         if (pass_start)
            in_count_ff <= '0;
         else if (input_beat && (32'(in_count_ff) < MAX_INPUTS))
            in_count_ff <= in_count_ff + 1'b1;
         if (pass_start)      hw_cnt_ff <= '0;
         else if (hid_result) hw_cnt_ff <= hw_cnt_ff + 1'b1;
         if (pass_start)      out_cnt_ff <= '0;
         else if (out_result) out_cnt_ff <= out_cnt_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------- MAC pipe
   // s0 issue -> s1 operands read -> s2 product -> s3 saturated sum
   opnd_src_type             src1_ff;
   logic signed [WORD_W-1:0] opnd1_ff, x1;
   logic signed [ACC_W-1:0]  prod_ff, acc_ff, acc_base;
   logic signed [ACC_W:0]    sum;
   logic signed [ACC_W-1:0]  acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else begin
         t1_ff <= iss;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   always_comb begin
      case (src1_ff)
         SRC_INPUT:  x1 = in_rdata_ff;
         SRC_HIDDEN: x1 = WORD_W'(hid_rdata_ff);
         default:    x1 = opnd1_ff;
      endcase
      acc_base = t2_ff.first ? '0 : acc_ff;
      sum      = {acc_base[ACC_W-1], acc_base} + {prod_ff[ACC_W-1], prod_ff};
      // clamp on signed overflow
      if (sum[ACC_W] != sum[ACC_W-1])
         acc_in = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
         acc_in = sum[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      src1_ff  <= iss_src;
      opnd1_ff <= iss_opnd;
      prod_ff  <= w_rdata_ff * x1;
      if (t2_ff.valid) acc_ff <= acc_in;
   end

   term_tag_type sig_in_tag;
   always_comb begin
      sig_in_tag       = t3_ff;
      sig_in_tag.valid = t3_ff.valid && t3_ff.last;
   end

   rmlp_sigmoid u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (sig_in_tag),
      .in_acc    (acc_ff),
      .out_tag   (sig_tag),
      .out_value (sig_value),
      .busy      (sig_busy)
   );

   // ---------------------------------------------------------------- results
   // hold one result beat; a neuron is only started with this slot free
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)                     rsp_valid_ff <= 1'b0;
      else if (out_result)           rsp_valid_ff <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_result) begin
         rsp_output_value <= sig_value;
         rsp_output_index <= 4'(out_cnt_ff);
         rsp_output_last  <= (32'(out_cnt_ff) + 1 == 32'(no));
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------- checks
   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      out_result |-> !rsp_valid_ff)
      else $error("output result overwrote a pending beat");

   a_hidden_in_range: assert property (@(posedge clock) disable iff (reset)
      hid_result |-> (32'(hw_cnt_ff) < 32'(nh)))
      else $error("hidden result beyond active neurons");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> pipe_empty)
      else $error("pipeline busy while idle");

   a_update_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> pipe_empty)
      else $error("frame update overlaps hidden layer");

endmodule

/* tb/rmlp_tb_pkg.sv */
// ----------------------------------------------------------------------------
// rmlp_tb_pkg: codes shared by the recurrent MLP testbench files
// Register indexes of the configuration port, beat operations and the
// block's size limits as seen by the checker and the stimulus.
// ----------------------------------------------------------------------------
package rmlp_tb_pkg;

   typedef enum logic [2:0] {
      REG_NUM_INPUTS   = 3'd0,
      REG_NUM_HIDDEN   = 3'd1,
      REG_NUM_OUTPUTS  = 3'd2,
      REG_MEMORY_ORDER = 3'd3,
      REG_BIAS_VALUE   = 3'd4,
      REG_MEMORY_DECAY = 3'd5
   } csr_reg_e;

   typedef enum logic {
      OP_WEIGHT = 1'b0,
      OP_INPUT  = 1'b1
   } beat_op_e;

   localparam int LIM_INPUTS  = 32;
   localparam int LIM_HIDDEN  = 32;
   localparam int LIM_OUTPUTS = 16;
   localparam int LIM_ORDER   = 4;
   localparam int LIM_DECAY   = 4096;
   localparam int WSTORE_SIZE = 8192;

endpackage

/* tb/recurrent_mlp_checker.sv */
// ----------------------------------------------------------------------------
// recurrent_mlp_checker: scoreboard for the recurrent MLP engine
// Snoops configuration writes and accepted weight and input beats,
// recomputes each forward pass in fixed point and compares every result beat in order.
// ----------------------------------------------------------------------------
module recurrent_mlp_checker
   import rmlp_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [12:0] req_weight_address,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_input_value,
   input  logic        req_input_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [12:0] rsp_output_value,
   input  logic [3:0]  rsp_output_index,
   input  logic        rsp_output_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [12:0] value;
      logic [3:0]  index;
      logic        last;
   } neuron_result_t;

   neuron_result_t    result_q[$];

   logic [5:0]        cfg_inputs, cfg_hidden;
   logic [4:0]        cfg_outputs;
   logic [2:0]        cfg_order;
   logic signed [15:0] cfg_bias;
   logic [12:0]       cfg_decay;

   logic signed [15:0] wstore [WSTORE_SIZE];
   logic signed [15:0] in_vec [LIM_INPUTS];
   int                in_fill;
   logic [12:0]       hid_act [LIM_HIDDEN];
   logic [15:0]       frames [LIM_ORDER*LIM_HIDDEN];
   int                errors;

   initial begin
      errors     = 0;
      fail_count = 0;
      pending    = 0;
   end

   function automatic int sig_knot(input int k);
      case (k)
         0: return 2048;   1: return 2550;   2: return 2994;   3: return 3349;
         4: return 3608;   5: return 3785;   6: return 3902;   7: return 3976;
         8: return 4022;   9: return 4051;   10: return 4069;  11: return 4079;
         12: return 4086;  13: return 4090;  14: return 4092;  15: return 4094;
         default: return 4095;
      endcase
   endfunction

   // Piecewise-linear logistic on the Q8.24 sum, result Q0.12.
   function automatic logic [12:0] logistic(input longint acc);
      longint mag, u, seg, frac, v;
      mag = (acc < 0) ? -acc : acc;
      u = mag >>> 12;
      seg = u >>> 11;
      frac = u & 2047;
      if (seg >= 16) v = 4095;
      else v = sig_knot(int'(seg)) +
               (((sig_knot(int'(seg) + 1) - sig_knot(int'(seg))) * frac + 1024) >>> 11);
      if (acc < 0) v = 4096 - v;
      return v[12:0];
   endfunction

   function automatic longint sat_mac(input longint acc, input longint w, input longint x);
      longint s;
      s = acc + w * x;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
   endfunction

   function automatic int clip(input int v, input int m);
      return (v > m) ? m : v;
   endfunction

   function automatic logic [15:0] fade(input int v, input int d);
      int p;
      p = (v * d + 2048) >>> 12;
      return p[15:0];
   endfunction

   function automatic longint wt(input int a);
      return longint'(wstore[a % WSTORE_SIZE]);
   endfunction

   // Hidden layer, frame shift, then output layer; queue the output beats.
   task automatic forward_pass();
      int ni, nh, no, mo, d, l0, a, i, j, f;
      longint acc, bias;
      neuron_result_t r;
      ni = clip(cfg_inputs, LIM_INPUTS);
      nh = clip(cfg_hidden, LIM_HIDDEN);
      no = clip(cfg_outputs, LIM_OUTPUTS);
      mo = clip(cfg_order, LIM_ORDER);
      d = clip(cfg_decay, LIM_DECAY);
      bias = longint'(cfg_bias);
      l0 = ni + nh * mo + 1;
      for (j = 0; j < nh; j++) begin
         a = j * l0;
         acc = 0;
         for (i = 0; i < ni; i++) begin
            acc = sat_mac(acc, wt(a), longint'(in_vec[i]));
            a++;
         end
         for (f = 0; f < mo; f++)
            for (i = 0; i < nh; i++) begin
               acc = sat_mac(acc, wt(a), longint'(frames[f*LIM_HIDDEN+i]));
               a++;
            end
         acc = sat_mac(acc, wt(a), bias);
         hid_act[j] = logistic(acc);
      end
      if (mo > 0) begin
         for (f = 0; f + 1 < mo; f++)
            for (i = 0; i < nh; i++)
               frames[f*LIM_HIDDEN+i] = fade(frames[(f+1)*LIM_HIDDEN+i], d);
         for (i = 0; i < nh; i++)
            frames[(mo-1)*LIM_HIDDEN+i] = fade(hid_act[i], d);
      end
      for (j = 0; j < no; j++) begin
         a = nh * l0 + j * (nh + 1);
         acc = 0;
         for (i = 0; i < nh; i++) begin
            acc = sat_mac(acc, wt(a), longint'(hid_act[i]));
            a++;
         end
         acc = sat_mac(acc, wt(a), bias);
         r.value = logistic(acc);
         r.index = j[3:0];
         r.last = (j + 1 == no);
         result_q.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      neuron_result_t want;
      if (reset) begin
         cfg_inputs <= 6'd1;
         cfg_hidden <= 6'd1;
         cfg_outputs <= 5'd1;
         cfg_order <= 3'd0;
         cfg_bias <= 16'sd4096;
         cfg_decay <= 13'd4096;
         in_fill = 0;
         for (int k = 0; k < LIM_ORDER*LIM_HIDDEN; k++) frames[k] = '0;
         result_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_NUM_INPUTS:   cfg_inputs <= csr_data[5:0];
               REG_NUM_HIDDEN:   cfg_hidden <= csr_data[5:0];
               REG_NUM_OUTPUTS:  cfg_outputs <= csr_data[4:0];
               REG_MEMORY_ORDER: cfg_order <= csr_data[2:0];
               REG_BIAS_VALUE:   cfg_bias <= csr_data;
               REG_MEMORY_DECAY: cfg_decay <= csr_data[12:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_WEIGHT) begin
               wstore[req_weight_address] = req_weight_value;
            end else begin
               // drop elements past the end of the vector
               if (in_fill < LIM_INPUTS) begin
                  in_vec[in_fill] = req_input_value;
                  in_fill++;
               end
               if (req_input_last) begin
                  in_fill = 0;
                  forward_pass();
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("result beat with nothing expected: value %0d index %0d",
                      rsp_output_value, rsp_output_index);
               errors++;
            end else begin
               want = result_q.pop_front();
               if (rsp_output_value !== want.value) begin
                  $error("output_value expected %0d actual %0d", want.value,
                         rsp_output_value);
                  errors++;
               end
               if (rsp_output_index !== want.index) begin
                  $error("output_index expected %0d actual %0d", want.index,
                         rsp_output_index);
                  errors++;
               end
               if (rsp_output_last !== want.last) begin
                  $error("output_last expected %0d actual %0d", want.last,
                         rsp_output_last);
                  errors++;
               end
            end
         end
      end
      fail_count <= errors;
      pending <= result_q.size();
   end

endmodule

/* tb/tb_recurrent_mlp_inference.sv */
// ----------------------------------------------------------------------------
// tb_recurrent_mlp_inference: regression for the recurrent MLP engine
// Loads weights, streams input vectors under several configurations with
// random idling on both channels and leaves all checking to the
// scoreboard beside the block; reports one verdict at the end.
// ----------------------------------------------------------------------------
module tb_recurrent_mlp_inference;
   import rmlp_tb_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = 1'b0;
   logic [12:0] req_weight_address = '0;
   logic signed [15:0] req_weight_value = '0;
   logic signed [15:0] req_input_value = '0;
   logic        req_input_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [12:0] rsp_output_value;
   logic [3:0]  rsp_output_index;
   logic        rsp_output_last;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int fail_count;
   int pending;

   // idle percentages of the two channels; the stimulus moves through modes
   int send_idle_pct = 38;
   int recv_idle_pct = 76;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycles = 0;

   // effective configuration, already clipped to the block's limits
   int eff_ni = 1, eff_nh = 1, eff_no = 1, eff_mo = 0;
   int vec_high = 0;      // vector positions written so far
   int rnd_beats = 0;
   int rnd_results = 0;

   recurrent_mlp_inference dut (.*);

   recurrent_mlp_checker scoreboard (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Give up on a hung block.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("recurrent_mlp_inference regression: fail");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off when the stimulus asks.
   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen <= hold_reqs;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic int clip(input int v, input int m);
      return (v > m) ? m : v;
   endfunction

   // Mix of small values, full-range values and both extremes.
   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(9);
      case (r)
         0: return $urandom;
         1: return 16'h7fff;
         2: return 16'h8000;
         default: return 16'($urandom_range(8191) - 4096);
      endcase
   endfunction

   // Cycles one pass may need under the current setting, with margin.
   function automatic int pass_cycles();
      return eff_nh * (eff_ni + eff_mo * LIM_HIDDEN + 2) + LIM_HIDDEN
             + eff_no * (eff_nh + 8) + 12 + 64;
   endfunction

   // Offer one beat and hold it until accepted, then maybe idle.
   task automatic send_beat(input beat_op_e op, input logic [12:0] addr,
                            input logic [15:0] wval, input logic [15:0] ival,
                            input logic last);
      req_valid <= 1'b1;
      req_operation <= op;
      req_weight_address <= addr;
      req_weight_value <= wval;
      req_input_value <= ival;
      req_input_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_weight(input int addr, input logic [15:0] wval);
      send_beat(OP_WEIGHT, addr[12:0], wval, $urandom, $urandom_range(1));
   endtask

   // Stream one vector; the last beat starts the pass.
   task automatic send_vector(input int len);
      for (int k = 0; k < len; k++)
         send_beat(OP_INPUT, $urandom, $urandom, pick_word(), k == len - 1);
      if (clip(len, LIM_INPUTS) > vec_high) vec_high = clip(len, LIM_INPUTS);
   endtask

   // Length of a random vector; never leaves a used position unwritten.
   function automatic int vector_len();
      int lo;
      if (vec_high < eff_ni) return eff_ni + $urandom_range(2);
      lo = (eff_ni > 2) ? eff_ni - 2 : 1;
      return $urandom_range(lo, eff_ni + 2);
   endfunction

   // Load every weight the current setting reads.
   task automatic load_weights();
      int span;
      span = eff_nh * (eff_ni + eff_nh * eff_mo + 1) + eff_no * (eff_nh + 1);
      for (int a = 0; a < span; a++) send_weight(a, pick_word());
   endtask

   // Drop valid, wait for every result, then let any silent pass finish.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (pass_cycles()) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_e idx, input int val, input int width);
      logic [15:0] mask;
      mask = 16'((32'd1 << width) - 1);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= (16'($urandom) & ~mask) | (16'(val) & mask);
      @(posedge clock);
   endtask

   // Write all six registers; only called with the block idle.
   task automatic configure(input int ni, input int nh, input int no,
                            input int mo, input int bias, input int decay);
      write_csr(REG_NUM_INPUTS, ni, 6);
      write_csr(REG_NUM_HIDDEN, nh, 6);
      write_csr(REG_NUM_OUTPUTS, no, 5);
      write_csr(REG_MEMORY_ORDER, mo, 3);
      write_csr(REG_BIAS_VALUE, bias, 16);
      write_csr(REG_MEMORY_DECAY, decay, 13);
      csr_write <= 1'b0;
      @(posedge clock);
      eff_ni = clip(ni & 63, LIM_INPUTS);
      eff_nh = clip(nh & 63, LIM_HIDDEN);
      eff_no = clip(no & 31, LIM_OUTPUTS);
      eff_mo = clip(mo & 7, LIM_ORDER);
   endtask

   task automatic set_mode();
      if (rnd_beats < 90) begin
         send_idle_pct = 38;
         recv_idle_pct = 76;
      end else if (rnd_beats < 180) begin
         send_idle_pct = 76;
         recv_idle_pct = 38;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin
      int phase, nvec, len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: one input, one hidden, one output; extreme inputs.
      load_weights();
      send_beat(OP_INPUT, 13'h1fff, 16'h7fff, 16'h7fff, 1'b1);
      vec_high = 1;
      send_beat(OP_INPUT, 13'h0000, 16'h8000, 16'h8000, 1'b1);
      drain();

      // Recurrent setting, most negative bias; overlong and short vectors.
      configure(3, 2, 2, 1, -32768, 4096);
      load_weights();
      send_weight(8191, 16'h8000);
      send_weight(0, 16'h7fff);
      send_vector(35);
      send_vector(1);
      send_vector(3);
      drain();

      // No hidden neurons: outputs see only the bias.
      configure(1, 0, 3, 0, 32767, 0);
      load_weights();
      send_vector(1);
      drain();

      // No outputs: passes still shift the frames but give no beats.
      configure(2, 2, 0, 2, 4096, 2048);
      load_weights();
      send_vector(2);
      send_vector(2);
      drain();

      // Counts and decay past their limits: run at the largest setting.
      configure(63, 40, 31, 7, 4096, 8191);
      load_weights();
      send_vector(32);
      send_vector(32);
      drain();

      phase = 0;
      while (rnd_beats < 270 || rnd_results < 48) begin
         set_mode();
         configure(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 6),
                   ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                   ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                   $urandom_range(7), $urandom,
                   ($urandom_range(3) == 0) ? 4096 : $urandom_range(8191));
         load_weights();
         nvec = $urandom_range(3, 5);
         // Hold the result channel off while vectors keep coming.
         if (phase == 2) hold_reqs = hold_reqs + 1;
         for (int v = 0; v < nvec; v++) begin
            // Pause mid-phase until every result has drained.
            if (phase == 4 && v == 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            if ($urandom_range(9) == 0) begin
               send_weight($urandom_range(WSTORE_SIZE - 1), pick_word());
               rnd_beats++;
            end
            len = vector_len();
            send_vector(len);
            rnd_beats += len;
            rnd_results += eff_no;
         end
         drain();
         phase++;
      end

      drain();
      if (fail_count == 0 && pending == 0)
         $display("recurrent_mlp_inference regression: pass");
      else
         $display("recurrent_mlp_inference regression: fail");
      $finish;
   end

endmodule

/* recurrent_mlp_inference.f */
sv/rmlp_pkg.sv
sv/rmlp_frame_cell.sv
sv/rmlp_sigmoid.sv
sv/recurrent_mlp_inference.sv
tb/rmlp_tb_pkg.sv
tb/recurrent_mlp_checker.sv
tb/tb_recurrent_mlp_inference.sv
